### sv/fpa_pkg.sv
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0]        action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               is_div;
    logic               is_mul;
    logic               div_zero;
    logic signed [31:0] simple_res;
    logic               cmp;
  } job_t;

endpackage

### sv/fpa_if.sv
interface fpa_req_if;
  import fpa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/fpa_front.sv
module fpa_front #(
  parameter int FRACTION_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  fpa_req_if.sink       req,
  output logic          q_valid,
  input  logic          q_ready,
  output fpa_pkg::job_t q_data
);
  import fpa_pkg::*;

  job_t job;
  logic lt_ab, lt_ba;
  logic signed [63:0] a_ext;

  always_comb begin
    lt_ab = req.data.operand_a < req.data.operand_b;
    lt_ba = req.data.operand_b < req.data.operand_a;
    a_ext = 64'(req.data.operand_a);
    job = '0;
    job.action = req.data.action;
    job.a = req.data.operand_a;
    job.b = req.data.operand_b;
    job.is_mul = req.data.action == OP_MUL;
    job.is_div = req.data.action == OP_DIV;
    job.div_zero = job.is_div && req.data.operand_b == 32'sd0;
    case (op_t'(req.data.action))
      OP_ADD: job.simple_res = req.data.operand_a + req.data.operand_b;
      OP_SUB: job.simple_res = req.data.operand_a - req.data.operand_b;
      OP_GT: job.cmp = lt_ba;
      OP_LT: job.cmp = lt_ab;
      OP_GE: job.cmp = !lt_ab;
      OP_LE: job.cmp = !lt_ba;
      OP_EQ: job.cmp = req.data.operand_a == req.data.operand_b;
      OP_NE: job.cmp = req.data.operand_a != req.data.operand_b;
      OP_MIN: job.simple_res = lt_ab ? req.data.operand_a : req.data.operand_b;
      OP_MAX: job.simple_res = lt_ba ? req.data.operand_a : req.data.operand_b;
      OP_INC: job.simple_res = req.data.operand_a + 32'sd1;
      OP_DEC: job.simple_res = req.data.operand_a - 32'sd1;
      OP_FROM_INT: job.simple_res = req.data.operand_a <<< FRACTION_BITS;
      OP_TO_INT: job.simple_res = 32'(a_ext >>> FRACTION_BITS);
      default: job.simple_res = '0;
    endcase
  end

  // Two-entry queue towards the back end.
  job_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign req.ready = count != 2'd2;
  assign q_valid = count != 2'd0;
  assign q_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) mem[wptr] <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (req.valid && req.ready) wptr <= ~wptr;
      if (q_valid && q_ready) rptr <= ~rptr;
      count <= count + 2'(req.valid && req.ready) - 2'(q_valid && q_ready);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !q_valid) else $error("valid from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready && !(req.valid && req.ready)) |=> (count == $past(count)))
    else $error("queue count moved without a beat");
endmodule

### sv/fpa_back.sv
module fpa_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  fpa_pkg::job_t q_data,
  fpa_rsp_if.source     rsp
);
  import fpa_pkg::*;

  localparam int Stages = 32 + FRACTION_BITS;
  localparam int Nw = 32 + FRACTION_BITS;
  localparam int Lat = Stages + 1;

  // Shared pipeline: every job walks the same depth so order is kept.
  logic        vld  [Lat+1];
  job_t        jb   [Stages+1];
  logic [Nw-1:0] rem [Stages+1];
  logic [Nw-1:0] num [Stages+1];
  logic [31:0]   den [Stages+1];
  logic          neg [Stages+1];
  logic signed [63:0] prod;

  logic stall;
  assign stall = rsp.valid && !rsp.ready;
  assign q_ready = !stall;

  logic [31:0] ma, mb;
  always_comb begin
    ma = q_data.a[31] ? 32'(-q_data.a) : 32'(q_data.a);
    mb = q_data.b[31] ? 32'(-q_data.b) : 32'(q_data.b);
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      jb[0] <= q_data;
      rem[0] <= '0;
      num[0] <= {ma, FRACTION_BITS'(0)};
      den[0] <= (mb == 32'd0) ? 32'd1 : mb;
      neg[0] <= q_data.a[31] ^ q_data.b[31];
      prod <= 64'(q_data.a) * 64'(q_data.b);
    end
  end

  // One restoring quotient bit per stage.
  for (genvar s = 0; s < Stages; s++) begin : g_div
    logic [Nw:0] trial;
    logic [Nw:0] diff;
    assign trial = {rem[s][Nw-1:0], num[s][Nw-1]};
    assign diff = trial - (Nw+1)'(den[s]);
    always_ff @(posedge clk) begin
      if (!stall) begin
        jb[s+1] <= (s == 0) ? jb[s] : jb[s];
        den[s+1] <= den[s];
        neg[s+1] <= neg[s];
        if (!diff[Nw]) begin
          rem[s+1] <= diff[Nw-1:0];
          num[s+1] <= {num[s][Nw-2:0], 1'b1};
        end else begin
          rem[s+1] <= trial[Nw-1:0];
          num[s+1] <= {num[s][Nw-2:0], 1'b0};
        end
      end
    end
  end

  // Product delay line alongside.
  logic [31:0] pline [Stages];
  always_ff @(posedge clk) begin
    if (!stall) begin
      pline[0] <= 32'(prod >>> FRACTION_BITS);
      for (int i = 1; i < Stages; i++) pline[i] <= pline[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= Lat; i++) vld[i] <= 1'b0;
    end else if (!stall) begin
      vld[0] <= q_valid;
      for (int i = 1; i <= Lat; i++) vld[i] <= vld[i-1];
    end
  end

  logic [31:0] qv;
  assign qv = num[Stages][31:0];

  always_ff @(posedge clk) begin
    if (!stall) begin
      rsp.data.compare_true <= jb[Stages].cmp;
      rsp.data.divide_by_zero <= jb[Stages].div_zero;
      if (jb[Stages].div_zero) rsp.data.result_value <= '0;
      else if (jb[Stages].is_div)
        rsp.data.result_value <= neg[Stages] ? -qv : qv;
      else if (jb[Stages].is_mul) rsp.data.result_value <= pline[Stages-1];
      else rsp.data.result_value <= jb[Stages].simple_res;
    end
  end

  assign rsp.valid = vld[Lat];

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.divide_by_zero) |-> rsp.data.result_value == '0)
    else $error("divide by zero with nonzero result");
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.compare_true) |-> !rsp.data.divide_by_zero)
    else $error("compare and divide flags together");
  assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(rsp.data)) else $error("result moved under stall");
endmodule

### sv/fixed_point_q24_8_alu_top.sv
// Channel  Dir  Beat payload
// req      in   action, operand_a, operand_b
// rsp      out  result_value, compare_true, divide_by_zero
// One beat per cycle sustained while rsp is ready; a beat passes the queue,
// input register, one divider stage per quotient bit, output register.
// The divider has 32 + FRACTION_BITS restoring stages; all operations share it.
// rst is synchronous and clears the queue and pipeline valid bits.
// A stalled rsp freezes the whole pipeline; the two-entry queue then fills.
module fixed_point_q24_8_alu_top #(
  parameter int FRACTION_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  fpa_req_if.sink   req,
  fpa_rsp_if.source rsp
);
  import fpa_pkg::*;

  logic q_valid, q_ready;
  job_t q_data;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst, .req, .q_valid, .q_ready, .q_data
  );
  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .rsp
  );
endmodule
